// ----- sv/utt_pkg.sv -----
// shared types and constants of the utf-8 to utf-16 transcoder
package utt_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned IdxW       = $clog2(MaxResults);
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam logic [15:0] ReplChar    = 16'hFFFD;
  localparam logic [20:0] SuppBase    = 21'h010000;
  localparam logic [20:0] UnicodeMax  = 21'h10FFFF;
  localparam logic [5:0]  HiSurrTag   = 6'b110110;
  localparam logic [5:0]  LoSurrTag   = 6'b110111;
  localparam logic [9:0]  MaxUnitsRst = 10'd255;

  // one accepted byte's worth of results, handed from decoder to serializer
  typedef struct packed {
    logic [CntW-1:0]                   cnt;
    logic                              term;
    logic [9:0]                        count;
    logic [MaxResults-1:0][15:0]       units;
  } job_t;

endpackage

// ----- sv/utt_if.sv -----
// handshake channels for input bytes and output code units
interface utt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface utt_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit_out;
  logic        is_terminator;
  logic [9:0]  unit_count;
  logic        last_of_run;

  modport source (output valid, output unit_out, output is_terminator,
                  output unit_count, output last_of_run, input ready);
  modport sink   (input valid, input unit_out, input is_terminator,
                  input unit_count, input last_of_run, output ready);
endinterface

// ----- sv/utt_front.sv -----
// byte decoder: sequence state, capacity tracking and result bundling
module utt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  utt_byte_if.sink       byte_i,
  input  logic           cfg_we_i,
  input  logic [9:0]     cfg_wdata_i,
  output logic           job_valid_o,
  input  logic           job_ready_i,
  output utt_pkg::job_t  job_o
);
  import utt_pkg::*;

  logic [9:0]  max_q;
  logic [1:0]  pb_q, pb_d;
  logic [1:0]  nb_q, nb_d;
  logic [20:0] cp_q, cp_d;
  logic [9:0]  uw_q, uw_d;

  logic        is_cont, seq_open, room_pos;
  logic [10:0] diff;
  logic [9:0]  rm, uw1;
  logic [1:0]  held, n_ff;
  logic [20:0] cp_new, v;
  logic [1:0]  pb_inc;
  logic        seq_done;
  logic        tail_en;
  logic [15:0] tail_unit;
  logic [7:0]  b;
  logic        accept;

  assign b        = byte_i.byte_in;
  assign is_cont  = (b[7:6] == 2'b10);
  assign seq_open = (pb_q != 2'd0);
  assign diff     = {1'b0, max_q} - {1'b0, uw_q};
  assign room_pos = (max_q > uw_q);
  assign rm       = room_pos ? diff[9:0] : 10'd0;
  assign held     = (seq_open && !is_cont) ? pb_q : 2'd0;
  assign n_ff     = (rm >= {8'd0, held}) ? held : rm[1:0];
  assign uw1      = uw_q + {8'd0, n_ff};
  assign cp_new   = {cp_q[14:0], b[5:0]};
  assign v        = cp_new - SuppBase;
  assign pb_inc   = pb_q + 2'd1;
  assign seq_done = (pb_inc == 2'd0) || ((pb_inc - 2'd1) >= nb_q);

  always_comb begin
    pb_d      = pb_q;
    nb_d      = nb_q;
    cp_d      = cp_q;
    uw_d      = uw_q;
    tail_en   = 1'b0;
    tail_unit = ReplChar;
    job_o.cnt   = '0;
    job_o.term  = 1'b0;
    job_o.count = '0;
    for (int i = 0; i < MaxResults; i++) begin
      job_o.units[i] = ReplChar;
    end

    if (seq_open && is_cont) begin
      if (seq_done) begin
        pb_d = '0;
        nb_d = '0;
        cp_d = '0;
        if (cp_new < SuppBase) begin
          if (rm >= 10'd1) begin
            job_o.cnt      = CntW'(1);
            job_o.units[0] = cp_new[15:0];
            uw_d           = uw_q + 10'd1;
          end
        end else if (cp_new <= UnicodeMax && rm >= 10'd2) begin
          // surrogate pair
          job_o.cnt      = CntW'(2);
          job_o.units[0] = {HiSurrTag, v[19:10]};
          job_o.units[1] = {LoSurrTag, v[9:0]};
          uw_d           = uw_q + 10'd2;
        end
      end else begin
        pb_d = pb_inc;
        cp_d = cp_new;
      end
    end else begin
      // a broken sequence flushes its held bytes as replacement chars first
      pb_d = '0;
      nb_d = '0;
      cp_d = '0;
      uw_d = uw1;
      if (b == 8'd0) begin
        tail_en     = 1'b1;
        tail_unit   = 16'd0;
        job_o.term  = 1'b1;
        job_o.count = uw1;
        uw_d        = '0;
      end else if (uw1 >= max_q) begin
        tail_en = 1'b0;
      end else if (b[7] == 1'b0) begin
        tail_en   = 1'b1;
        tail_unit = {8'd0, b};
        uw_d      = uw1 + 10'd1;
      end else if (b[7:5] == 3'b110) begin
        pb_d = 2'd1;
        nb_d = 2'd1;
        cp_d = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        pb_d = 2'd1;
        nb_d = 2'd2;
        cp_d = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        pb_d = 2'd1;
        nb_d = 2'd3;
        cp_d = {18'd0, b[2:0]};
      end else begin
        tail_en = 1'b1;
        uw_d    = uw1 + 10'd1;
      end
      job_o.cnt = CntW'(n_ff) + CntW'(tail_en);
      for (int i = 0; i < MaxResults; i++) begin
        job_o.units[i] = (i < int'(n_ff)) ? ReplChar : tail_unit;
      end
    end
  end

  assign byte_i.ready = job_ready_i;
  assign accept       = byte_i.valid && job_ready_i;
  assign job_valid_o  = byte_i.valid && (job_o.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxUnitsRst;
      pb_q  <= '0;
      nb_q  <= '0;
      cp_q  <= '0;
      uw_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (accept) begin
        pb_q <= pb_d;
        nb_q <= nb_d;
        cp_q <= cp_d;
        uw_q <= uw_d;
      end
    end
  end

endmodule

// ----- sv/utt_fifo.sv -----
// short request queue between decoder and serializer
module utt_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  utt_pkg::job_t  push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output utt_pkg::job_t  pop_data_o
);
  import utt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [LvlW-1:0] lvl_q;
  logic            do_push, do_pop;

  assign push_ready_o = (lvl_q != LvlW'(Depth));
  assign pop_valid_o  = (lvl_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        lvl_q <= lvl_q + LvlW'(1);
      end else if (do_pop && !do_push) begin
        lvl_q <= lvl_q - LvlW'(1);
      end
    end
  end

endmodule

// ----- sv/utt_back.sv -----
// serializer: sends a request's units one per cycle on the output channel while it is ready
module utt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  utt_pkg::job_t  job_i,
  utt_unit_if.source     unit_o
);
  import utt_pkg::*;

  job_t            cur_q;
  logic            cur_valid_q;
  logic [IdxW-1:0] idx_q;
  logic            is_last, term_now, out_fire;

  assign is_last  = (CntW'(idx_q) == (cur_q.cnt - CntW'(1)));
  assign term_now = cur_q.term && is_last;
  assign out_fire = cur_valid_q && unit_o.ready;

  assign unit_o.valid         = cur_valid_q;
  assign unit_o.unit_out      = term_now ? 16'd0 : cur_q.units[idx_q];
  assign unit_o.is_terminator = term_now;
  assign unit_o.unit_count    = term_now ? cur_q.count : 10'd0;
  assign unit_o.last_of_run   = is_last;

  assign job_ready_o = !cur_valid_q || (out_fire && is_last);

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      cur_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (job_ready_o) begin
      cur_valid_q <= job_valid_i;
      idx_q       <= '0;
    end else if (out_fire) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

endmodule

// ----- sv/utt_if_dummy_guard.sv -----
// registered copy of the queue push strobe, watched by the top-level checks
module utt_if_dummy_guard (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic a_i,
  output logic q_o
);
  logic q_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= 1'b0;
    end else begin
      q_q <= a_i;
    end
  end
  assign q_o = q_q;
endmodule

// ----- sv/utf8_to_utf16_transcoder.sv -----
// Top level of the UTF-8 to UTF-16 transcoder. One byte is accepted per clock
// whenever the internal request queue has room; the decoder turns each byte into
// zero to four results (replacement chars for a broken sequence, a unit, a
// surrogate pair or the terminator with the unit count) in the same cycle. The
// serializer sends one unit per cycle while the receiver is ready, so sustained
// input runs at one byte per cycle as long as bytes average at most one result.
// The first result of a byte passes through the queue and then the serializer's
// request register before it is presented; the queue (QueueDepth requests)
// absorbs output stalls.
module utf8_to_utf16_transcoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  utt_byte_if.sink    byte_i,
  utt_unit_if.source  unit_o,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i
);
  import utt_pkg::*;

  logic dec_valid, dec_ready, q_valid, q_ready, accept_seen;
  job_t dec_job, q_job;

  utt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_valid_o (dec_valid),
    .job_ready_i (dec_ready),
    .job_o       (dec_job)
  );

  utt_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (dec_valid),
    .push_ready_o (dec_ready),
    .push_data_i  (dec_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  utt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .unit_o      (unit_o)
  );

  utt_if_dummy_guard u_seen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (dec_valid && dec_ready),
    .q_o    (accept_seen)
  );

`ifndef SYNTHESIS
  // terminator always closes the run of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_o.valid && unit_o.is_terminator |-> unit_o.last_of_run)
    else $error("terminator not last of run");

  // count and unit fields are exclusive between terminator and data results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_o.valid && !unit_o.is_terminator |-> unit_o.unit_count == 10'd0)
    else $error("unit count on data result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_o.valid && unit_o.is_terminator |-> unit_o.unit_out == 16'd0)
    else $error("nonzero unit on terminator");

  // a request pushed last cycle must leave the queue non-empty or be in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_seen |-> q_valid || unit_o.valid)
    else $error("request lost between decoder and serializer");
`endif

endmodule

// ----- dv/tb.sv -----
// testbench for the utf-8 to utf-16 transcoder: byte strings in, utf-16 units checked
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utt_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [15:0] unit;
    logic        term;
    logic [9:0]  count;
    logic        last;
  } unit_rec_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    logic [15:0] unit;
    logic        term;
    logic [9:0]  count;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [9:0] cfg_wdata_i;

  utt_byte_if byte_if ();
  utt_unit_if unit_if ();

  utf8_to_utf16_transcoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_if),
    .unit_o      (unit_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  int unsigned cyc_cnt = 0;
  always @(posedge clk_i) cyc_cnt <= cyc_cnt + 1;

  // decoder state as the block should hold it
  logic [9:0]  cap_units;
  logic [1:0]  seq_held;
  logic [1:0]  seq_need;
  logic [20:0] seq_cp;
  logic [9:0]  str_units;

  unit_rec_t utf16_exp_q[$];
  unit_rec_t byte_res[$];
  logic [7:0] tx_q[$];

  int unsigned err_cnt = 0;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned burst_left = 0;
  bit          long_hold_req = 1'b0;

  // directed bytes; typed rows carry their single result
  dir_row_t dir_tbl [25] = '{
    '{8'h00, 1'b1, 16'h0000, 1'b1, 10'd0},
    '{8'h41, 1'b1, 16'h0041, 1'b0, 10'd0},
    '{8'h7F, 1'b1, 16'h007F, 1'b0, 10'd0},
    '{8'hC3, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'hA9, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'hE2, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h82, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'hAC, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'hF0, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h9F, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h98, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h80, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'hF4, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h90, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h80, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h80, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h80, 1'b1, 16'hFFFD, 1'b0, 10'd0},
    '{8'hFF, 1'b1, 16'hFFFD, 1'b0, 10'd0},
    '{8'hE2, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h82, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h41, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'hC0, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h80, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'hF0, 1'b0, 16'h0, 1'b0, 10'd0},
    '{8'h00, 1'b0, 16'h0, 1'b0, 10'd0}
  };

  function automatic void put_unit(input logic [15:0] u, input logic t, input logic [9:0] c);
    unit_rec_t r;
    r.unit  = u;
    r.term  = t;
    r.count = c;
    r.last  = 1'b0;
    byte_res.push_back(r);
  endfunction

  function automatic void clear_seq();
    seq_held = 2'd0;
    seq_need = 2'd0;
    seq_cp   = 21'd0;
  endfunction

  function automatic void start_seq(input logic [1:0] need, input logic [20:0] bits);
    seq_held = 2'd1;
    seq_need = need;
    seq_cp   = bits;
  endfunction

  function automatic void emit_code_point(input logic [20:0] cp);
    logic [9:0]  free_units;
    logic [20:0] off;
    free_units = (cap_units > str_units) ? cap_units - str_units : 10'd0;
    if (cp < SuppBase) begin
      if (free_units >= 10'd1) begin
        put_unit(cp[15:0], 1'b0, 10'd0);
        str_units = str_units + 10'd1;
      end
    end else if (cp <= UnicodeMax && free_units >= 10'd2) begin
      off = cp - SuppBase;
      put_unit({HiSurrTag, off[19:10]}, 1'b0, 10'd0);
      put_unit({LoSurrTag, off[9:0]}, 1'b0, 10'd0);
      str_units = str_units + 10'd2;
    end
  endfunction

  // results that one accepted byte should cause, left in byte_res
  function automatic void decode_byte(input logic [7:0] b);
    logic [1:0]  held;
    logic [20:0] cp;
    bit          seq_done;
    byte_res.delete();
    seq_done = 1'b0;
    if (seq_held != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        seq_cp   = {seq_cp[14:0], b[5:0]};
        seq_held = seq_held + 2'd1;
        if (seq_held == 2'd0 || seq_held > seq_need) begin
          cp = seq_cp;
          clear_seq();
          emit_code_point(cp);
        end
        seq_done = 1'b1;
      end else begin
        // broken sequence: one replacement per held byte while room is left, then redo as lead
        held = seq_held;
        clear_seq();
        for (int i = 0; i < held; i++) begin
          if (str_units >= cap_units) break;
          emit_code_point({5'd0, ReplChar});
        end
      end
    end
    if (!seq_done) begin
      if (b == 8'h00) begin
        put_unit(16'h0000, 1'b1, str_units);
        clear_seq();
        str_units = 10'd0;
      end else if (str_units >= cap_units) begin
        // full: byte ignored
      end else if (b[7] == 1'b0) begin
        emit_code_point({13'd0, b});
      end else if (b[7:5] == 3'b110) begin
        start_seq(2'd1, {16'd0, b[4:0]});
      end else if (b[7:4] == 4'b1110) begin
        start_seq(2'd2, {17'd0, b[3:0]});
      end else if (b[7:3] == 5'b11110) begin
        start_seq(2'd3, {18'd0, b[2:0]});
      end else begin
        emit_code_point({5'd0, ReplChar});
      end
    end
    if (byte_res.size() > 0) byte_res[byte_res.size()-1].last = 1'b1;
  endfunction

  // random stream: mostly well-formed characters, some terminators, noise and cut sequences
  function automatic void build_stream(input int unsigned n, input int unsigned term_pct);
    int unsigned pick;
    int unsigned need;
    int unsigned conts;
    logic [20:0] cp;
    logic [7:0]  r;
    tx_q.delete();
    while (tx_q.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < term_pct) begin
        tx_q.push_back(8'h00);
      end else if (pick < term_pct + 20) begin
        tx_q.push_back(8'($urandom_range(1, 127)));
      end else if (pick < term_pct + 33) begin
        cp = 21'($urandom_range(0, 32'h7FF));
        tx_q.push_back({3'b110, cp[10:6]});
        tx_q.push_back({2'b10, cp[5:0]});
      end else if (pick < term_pct + 48) begin
        cp = 21'($urandom_range(0, 32'hFFFF));
        tx_q.push_back({4'b1110, cp[15:12]});
        tx_q.push_back({2'b10, cp[11:6]});
        tx_q.push_back({2'b10, cp[5:0]});
      end else if (pick < term_pct + 66) begin
        // mostly valid supplementary points, sometimes beyond unicode
        if ($urandom_range(0, 3) != 0) cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
        else cp = 21'($urandom());
        tx_q.push_back({5'b11110, cp[20:18]});
        tx_q.push_back({2'b10, cp[17:12]});
        tx_q.push_back({2'b10, cp[11:6]});
        tx_q.push_back({2'b10, cp[5:0]});
      end else if (pick < term_pct + 80) begin
        need  = $urandom_range(1, 3);
        conts = $urandom_range(0, need - 1);
        r = 8'($urandom());
        case (need)
          1:       tx_q.push_back({3'b110, r[4:0]});
          2:       tx_q.push_back({4'b1110, r[3:0]});
          default: tx_q.push_back({5'b11110, r[2:0]});
        endcase
        repeat (conts) tx_q.push_back({2'b10, 6'($urandom())});
      end else begin
        tx_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input unit_rec_t typed_rec);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    byte_if.valid   <= 1'b1;
    byte_if.byte_in <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    decode_byte(b);
    if (typed) utf16_exp_q.push_back(typed_rec);
    else foreach (byte_res[i]) utf16_exp_q.push_back(byte_res[i]);
  endtask

  task automatic wait_drained(input int unsigned tail);
    while (utf16_exp_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_cap(input logic [9:0] v);
    wait_drained(8);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_units = v;
  endtask

  // receiver: checks every accepted unit and stalls on its own
  initial begin
    int unsigned hold_left;
    unit_rec_t   got;
    unit_rec_t   want;
    hold_left = 0;
    unit_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (unit_if.valid && unit_if.ready) begin
        got = '{unit: unit_if.unit_out, term: unit_if.is_terminator,
                count: unit_if.unit_count, last: unit_if.last_of_run};
        if (utf16_exp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: expected no unit, got unit %h term %b count %0d last %b",
                   $time, got.unit, got.term, got.count, got.last);
        end else begin
          want = utf16_exp_q.pop_front();
          if (got.unit !== want.unit || got.term !== want.term ||
              got.count !== want.count || got.last !== want.last) begin
            err_cnt++;
            $display("%0t: expected unit %h term %b count %0d last %b, got %h %b %0d %b",
                     $time, want.unit, want.term, want.count, want.last,
                     got.unit, got.term, got.count, got.last);
          end
        end
      end
      if (hold_left == 0 && long_hold_req) begin
        hold_left = 400;
        long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        unit_if.ready <= 1'b0;
      end else begin
        unit_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    wait (cyc_cnt >= CycleLimit);
    $display("%0t: timeout with %0d units outstanding", $time, utf16_exp_q.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int        phase_cap [12];
    int        phase_len [12];
    int        cap;
    unit_rec_t rec;
    phase_cap = '{1023, 0, 1, 2, 3, 1023, -1, -1, 4, -1, 255, 1};
    phase_len = '{36, 16, 20, 20, 20, 48, 30, 30, 20, 30, 36, 10};
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 10'd0;
    byte_if.valid   = 1'b0;
    byte_if.byte_in = 8'h00;
    gap_pct   = 30;
    stall_pct = 20;
    cap_units = MaxUnitsRst;
    clear_seq();
    str_units = 10'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      rec = '{unit: dir_tbl[i].unit, term: dir_tbl[i].term, count: dir_tbl[i].count,
              last: 1'b1};
      send_byte(dir_tbl[i].b, dir_tbl[i].typed, rec);
    end
    byte_if.valid <= 1'b0;

    for (int ph = 0; ph < 12; ph++) begin
      cap = (phase_cap[ph] < 0) ? $urandom_range(4, 60) : phase_cap[ph];
      write_cap(10'(cap));
      case (ph % 3)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 25; stall_pct = 30; end
        default: begin gap_pct = 50; stall_pct = 60; end
      endcase
      // output held off for a long stretch so the request queue fills
      if (ph == 5) long_hold_req = 1'b1;
      build_stream(phase_len[ph], (cap < 8) ? 18 : 8);
      foreach (tx_q[i]) send_byte(tx_q[i], 1'b0, '0);
      byte_if.valid <= 1'b0;
    end

    wait_drained(20);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
